// ===== hdl/rdsc_pkg.sv =====
package rdsc_pkg;

   localparam int NUMBER_W      = 64;
   localparam int CHAR_W        = 7;
   localparam int TOTAL_W       = 7;
   localparam int RADIX_W       = 6;
   localparam int MIN_WIDTH_W   = 7;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 7;
   localparam int DIGIT_W       = 6;
   localparam int STEP_BITS     = 8;

   localparam int MAX_DIGITS_DEFAULT = 64;
   localparam int VALUE_BITS_DEFAULT = 64;

   typedef logic [NUMBER_W-1:0]    number_type;
   typedef logic [CHAR_W-1:0]      char_type;
   typedef logic [TOTAL_W-1:0]     total_type;
   typedef logic [RADIX_W-1:0]     radix_type;
   typedef logic [MIN_WIDTH_W-1:0] min_width_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [DIGIT_W-1:0]     digit_type;

   localparam csr_index_type REG_RADIX     = 1'd0;
   localparam csr_index_type REG_MIN_WIDTH = 1'd1;

   localparam radix_type     RADIX_RESET     = 6'd16;
   localparam min_width_type MIN_WIDTH_RESET = 7'd16;
   localparam radix_type     RADIX_LOW       = 6'd2;
   localparam radix_type     RADIX_HIGH      = 6'd36;
   localparam digit_type     DECIMAL_LIMIT   = 6'd10;

   localparam char_type CHAR_ZERO   = 7'h30;
   localparam char_type CHAR_LETTER = 7'h41;

   typedef struct packed {
      logic load;
      logic div_step;
      logic setup;
      logic fetch;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic digit_done;
      logic conv_end;
      logic last;
   } sts_type;

   function automatic char_type digit_to_ascii(digit_type d);
      char_type c;
      if (d < DECIMAL_LIMIT) begin
         c = CHAR_ZERO + char_type'(d);
      end else begin
         c = CHAR_LETTER + char_type'(d - DECIMAL_LIMIT);
      end
      return c;
   endfunction

endpackage

// ===== hdl/rdsc_if.sv =====
interface rdsc_req_if;
   logic                 valid;
   logic                 ready;
   rdsc_pkg::number_type number_in;

   modport source (output valid, output number_in, input ready);
   modport sink (input valid, input number_in, output ready);
endinterface

interface rdsc_rsp_if;
   logic                valid;
   logic                ready;
   rdsc_pkg::char_type  digit_char;
   rdsc_pkg::total_type digit_total;
   logic                last_char;

   modport source (output valid, output digit_char, output digit_total, output last_char,
                   input ready);
   modport sink (input valid, input digit_char, input digit_total, input last_char,
                 output ready);
endinterface

interface rdsc_csr_if;
   logic                    valid;
   logic                    ready;
   rdsc_pkg::csr_index_type index;
   rdsc_pkg::csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rdsc_ctrl.sv =====
module rdsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rdsc_pkg::cmd_type cmd,
   input  rdsc_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_SETUP,
      S_FETCH,
      S_SHOW
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      req_fire;
   logic      rsp_fire;

   assign req_fire  = req_valid && req_ready_ff;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = req_fire;
      cmd.div_step = (state_ff == S_DIV);
      cmd.setup    = (state_ff == S_SETUP);
      cmd.fetch    = (state_ff == S_FETCH);
      cmd.advance  = rsp_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  req_ready_ff <= 1'b0;
                  state_ff     <= S_DIV;
               end else begin
                  req_ready_ff <= 1'b1;
               end
            end
            S_DIV: begin
               if (sts.digit_done && sts.conv_end) begin
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               state_ff <= S_FETCH;
            end
            S_FETCH: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_SHOW;
            end
            S_SHOW: begin
               if (rsp_fire) begin
                  rsp_valid_ff <= 1'b0;
                  if (sts.last) begin
                     req_ready_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     state_ff <= S_FETCH;
                  end
               end
            end
            default: begin
               req_ready_ff <= 1'b0;
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/rdsc_datapath.sv =====
module rdsc_datapath #(
   parameter int MAX_DIGITS = rdsc_pkg::MAX_DIGITS_DEFAULT,
   parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rdsc_pkg::number_type    number_in,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  rdsc_pkg::csr_index_type csr_index,
   input  rdsc_pkg::csr_data_type  csr_data,
   input  rdsc_pkg::cmd_type       cmd,
   output rdsc_pkg::sts_type       sts,
   output rdsc_pkg::char_type      digit_char,
   output rdsc_pkg::total_type     digit_total,
   output logic                    last_char
);

   localparam int STEP      = rdsc_pkg::STEP_BITS;
   localparam int WORK_BITS = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
   localparam int NCH       = WORK_BITS / STEP;
   localparam int CH_W      = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
   localparam int AW        = $clog2(MAX_DIGITS);
   localparam int DW        = rdsc_pkg::DIGIT_W;

   localparam logic [CH_W-1:0]  CHUNK_LAST = CH_W'(NCH - 1);
   localparam logic [CNT_W-1:0] COUNT_LAST = CNT_W'(MAX_DIGITS - 1);
   localparam logic [CNT_W-1:0] COUNT_MAX  = CNT_W'(MAX_DIGITS);
   localparam rdsc_pkg::min_width_type WIDTH_CAP = rdsc_pkg::min_width_type'(MAX_DIGITS);

   rdsc_pkg::radix_type     radix_ff;
   rdsc_pkg::min_width_type min_width_ff;

   logic [WORK_BITS-1:0] quot_ff;
   logic [WORK_BITS-1:0] quot_in;
   logic [DW-1:0]        rem_ff;
   logic [DW-1:0]        rem_in;
   logic [CH_W-1:0]      chunk_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     total_ff;
   logic [CNT_W-1:0]     pad_ff;
   logic [CNT_W-1:0]     k_ff;
   logic                 pad_flag_ff;
   logic                 last_ff;
   logic [DW-1:0]        rd_ff;
   logic [DW-1:0]        digit_store [MAX_DIGITS];

   rdsc_pkg::radix_type     base;
   rdsc_pkg::min_width_type width_cap;
   logic [CNT_W-1:0]        width_eff;
   logic [CNT_W-1:0]        total_in;
   logic [CNT_W-1:0]        pos;
   logic [DW:0]             r;
   logic                    digit_done;

   assign csr_ready = 1'b1;

   always_comb begin
      if (radix_ff < rdsc_pkg::RADIX_LOW) begin
         base = rdsc_pkg::RADIX_LOW;
      end else if (radix_ff > rdsc_pkg::RADIX_HIGH) begin
         base = rdsc_pkg::RADIX_HIGH;
      end else begin
         base = radix_ff;
      end
   end

   // eight restoring long-division steps per cycle, top bits first
   always_comb begin
      r       = {1'b0, rem_ff};
      quot_in = quot_ff;
      for (int i = 0; i < STEP; i++) begin
         r       = {r[DW-1:0], quot_in[WORK_BITS-1]};
         quot_in = {quot_in[WORK_BITS-2:0], 1'b0};
         if (r >= {1'b0, base}) begin
            r          = r - {1'b0, base};
            quot_in[0] = 1'b1;
         end
      end
      rem_in = r[DW-1:0];
   end

   assign digit_done     = (chunk_ff == CHUNK_LAST);
   assign sts.digit_done = digit_done;
   assign sts.conv_end   = (quot_in == '0) || (count_ff == COUNT_LAST);
   assign sts.last       = last_ff;

   assign width_cap = (min_width_ff > WIDTH_CAP) ? WIDTH_CAP : min_width_ff;
   assign width_eff = width_cap[CNT_W-1:0];
   assign total_in  = (count_ff > width_eff) ? count_ff : width_eff;
   assign pos       = count_ff - 1'b1 - (k_ff - pad_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= rdsc_pkg::RADIX_RESET;
         min_width_ff <= rdsc_pkg::MIN_WIDTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rdsc_pkg::REG_RADIX:     radix_ff     <= csr_data[rdsc_pkg::RADIX_W-1:0];
            rdsc_pkg::REG_MIN_WIDTH: min_width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff  <= '0;
         rem_ff   <= '0;
         chunk_ff <= '0;
         count_ff <= '0;
         k_ff     <= '0;
         total_ff <= '0;
         pad_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            quot_ff  <= WORK_BITS'(number_in[VALUE_BITS-1:0]);
            rem_ff   <= '0;
            chunk_ff <= '0;
            count_ff <= '0;
         end else if (cmd.div_step) begin
            quot_ff <= quot_in;
            if (digit_done) begin
               rem_ff   <= '0;
               chunk_ff <= '0;
               if (count_ff != COUNT_MAX) begin
                  count_ff <= count_ff + 1'b1;
               end
            end else begin
               rem_ff   <= rem_in;
               chunk_ff <= chunk_ff + 1'b1;
            end
         end
         if (cmd.setup) begin
            total_ff <= total_in;
            pad_ff   <= total_in - count_ff;
            k_ff     <= '0;
         end else if (cmd.advance) begin
            k_ff <= k_ff + 1'b1;
         end
         if (cmd.fetch) begin
            last_ff <= ((k_ff + 1'b1) == total_ff);
         end
      end
   end

   // digit memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.div_step && digit_done) begin
         digit_store[count_ff[AW-1:0]] <= rem_in;
      end
      if (cmd.fetch) begin
         rd_ff       <= digit_store[pos[AW-1:0]];
         pad_flag_ff <= (k_ff < pad_ff);
      end
   end

   assign digit_char  = pad_flag_ff ? rdsc_pkg::CHAR_ZERO : rdsc_pkg::digit_to_ascii(rd_ff);
   assign digit_total = rdsc_pkg::total_type'(total_ff);
   assign last_char   = last_ff;

endmodule

// ===== hdl/radix_digit_string_converter_top.sv =====
// radix digit string converter
//
// req_ch takes one unsigned value per word; rsp_ch returns its ASCII digits,
// most significant first, one character per word, with digit_total and
// last_char on every word. csr_ch writes radix (index 0) and min_width
// (index 1); always ready; write it only while the block is idle (unchecked).
//
// one value at a time: req_ch.ready is high only while idle
// each digit is one long division of the remaining quotient by the radix in
// the long-division unit, which retires 8 quotient bits per cycle while it
// divides; then a setup step, then each character is read through the
// registered read port of the digit memory
//
// reset: radix and min_width return to 16, control goes idle
// a stalled rsp_ch holds the current character until it is taken
module radix_digit_string_converter_top #(
   parameter int MAX_DIGITS = rdsc_pkg::MAX_DIGITS_DEFAULT,
   parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rdsc_req_if.sink   req_ch,
   rdsc_rsp_if.source rsp_ch,
   rdsc_csr_if.sink   csr_ch
);

   rdsc_pkg::cmd_type cmd;
   rdsc_pkg::sts_type sts;

   rdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rdsc_datapath #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .number_in   (req_ch.number_in),
      .csr_valid   (csr_ch.valid),
      .csr_ready   (csr_ch.ready),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .cmd         (cmd),
      .sts         (sts),
      .digit_char  (rsp_ch.digit_char),
      .digit_total (rsp_ch.digit_total),
      .last_char   (rsp_ch.last_char)
   );

endmodule

// ===== verif/rdsc_digit_checker.sv =====
`timescale 1ns / 1ps

module rdsc_digit_checker (
   input  logic clock,
   input  logic reset,
   rdsc_req_if  req_mon,
   rdsc_rsp_if  rsp_mon,
   rdsc_csr_if  csr_mon,
   output int   errors,
   output int   pending,
   output int   chars_checked
);
   import rdsc_pkg::*;

   typedef struct {
      char_type  ch;
      total_type total;
      logic      last;
   } char_word_t;

   char_word_t    expected_chars[$];
   radix_type     radix_reg;
   min_width_type width_reg;

   task automatic report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
   endtask

   // digits least significant first, then emitted from the top with padding
   function automatic void convert_number(number_type value);
      int         base;
      int         width;
      int         count;
      int         total;
      digit_type  digits[64];
      digit_type  d;
      number_type q;
      char_word_t w;
      base = (radix_reg < RADIX_LOW) ? 2 : (radix_reg > RADIX_HIGH) ? 36 : int'(radix_reg);
      width = (width_reg > 64) ? 64 : int'(width_reg);
      q = value;
      count = 0;
      do begin
         if (count < 64) begin
            digits[count] = digit_type'(q % number_type'(base));
            count++;
         end
         q = q / number_type'(base);
      end while (q != 0);
      total = (count > width) ? count : width;
      for (int k = 0; k < total; k++) begin
         d = (k < total - count) ? digit_type'(0) : digits[total - 1 - k];
         if (d < 10) begin
            w.ch = CHAR_ZERO + char_type'(d);
         end else begin
            w.ch = CHAR_LETTER + char_type'(d - 10);
         end
         w.total = total_type'(total);
         w.last = (k == total - 1);
         expected_chars.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      char_word_t w;
      if (reset) begin
         radix_reg = RADIX_RESET;
         width_reg = MIN_WIDTH_RESET;
         expected_chars.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == REG_RADIX) begin
               radix_reg = radix_type'(csr_mon.data);
            end else begin
               width_reg = min_width_type'(csr_mon.data);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            convert_number(req_mon.number_in);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_chars.size() == 0) begin
               report($sformatf("unexpected word char %0d", rsp_mon.digit_char));
            end else begin
               w = expected_chars.pop_front();
               chars_checked++;
               if (rsp_mon.digit_char !== w.ch) begin
                  report($sformatf("digit_char expected %0d got %0d", w.ch, rsp_mon.digit_char));
               end
               if (rsp_mon.digit_total !== w.total) begin
                  report($sformatf("digit_total expected %0d got %0d", w.total,
                                   rsp_mon.digit_total));
               end
               if (rsp_mon.last_char !== w.last) begin
                  report($sformatf("last_char expected %0d got %0d", w.last,
                                   rsp_mon.last_char));
               end
            end
         end
      end
      pending = expected_chars.size();
   end

endmodule

// ===== verif/radix_digit_string_converter_top_test.sv =====
`timescale 1ns / 1ps

module radix_digit_string_converter_top_test;
   import rdsc_pkg::*;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   int   chars_checked;
   int   values_sent;
   bit   no_idle;
   bit   hold_request;
   int   hold_left;

   rdsc_req_if req_ch ();
   rdsc_rsp_if rsp_ch ();
   rdsc_csr_if csr_ch ();

   radix_digit_string_converter_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   rdsc_digit_checker digit_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .errors        (errors),
      .pending       (pending),
      .chars_checked (chars_checked)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // receiver side, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = 300;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else if (no_idle) begin
         rsp_ch.ready = 1'b1;
      end else begin
         rsp_ch.ready = ($urandom_range(0, 99) >= 10);
      end
   end

   function automatic number_type random_number();
      number_type v;
      v = {$urandom(), $urandom()};
      case ($urandom_range(0, 5))
         0: v = v;
         1: v = v >> $urandom_range(0, 63);
         2: v = '0;
         3: v = '1;
         4: v = number_type'($urandom_range(0, 1000));
         default: v = v >> $urandom_range(48, 63);
      endcase
      return v;
   endfunction

   task automatic send_number(number_type value);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 10) begin
            req_ch.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid = 1'b1;
      req_ch.number_in = value;
      do @(posedge clock); while (!req_ch.ready);
      values_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, csr_data_type data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data = data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic set_config(int radix, int width);
      wait_idle();
      write_reg(REG_RADIX, {1'($urandom_range(0, 1)), radix_type'(radix)});
      write_reg(REG_MIN_WIDTH, csr_data_type'(width));
   endtask

   initial begin
      int radix;
      int width;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.number_in = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_RADIX;
      csr_ch.data = '0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      hold_left = 0;
      values_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: hex, width 16
      send_number('0);
      send_number('1);
      send_number(64'd1);
      send_number(64'hDEAD_BEEF_0123_4567);

      set_config(2, 0);
      send_number('0);
      send_number('1);
      send_number(64'd1);
      send_number(64'h8000_0000_0000_0000);

      set_config(36, 64);
      send_number('1);
      send_number(64'd35);
      send_number(64'd36);
      send_number('0);

      // radix below two and above thirty-six; width above the store, then a small width
      set_config(0, 127);
      send_number(64'd5);
      send_number(64'd1);
      set_config(63, 65);
      send_number(64'd1295);
      send_number('1);
      set_config(1, 3);
      send_number(64'd6);

      set_config(10, 0);
      send_number(64'd10000000000000000000);
      send_number('1);
      send_number(64'd9);

      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 3))
            0: radix = 2;
            1: radix = 36;
            default: radix = $urandom_range(0, 63);
         endcase
         case ($urandom_range(0, 3))
            0: width = $urandom_range(0, 20);
            1: width = 64;
            2: width = 127;
            default: width = $urandom_range(0, 127);
         endcase
         set_config(radix, width);
         no_idle = (phase == 4);
         if (phase == 2) hold_request = 1'b1;
         for (int i = 0; i < 25; i++) begin
            if (phase == 5 && i == 12) begin
               req_ch.valid = 1'b0;
               while (pending != 0) @(negedge clock);
            end
            send_number(random_number());
         end
      end
      req_ch.valid = 1'b0;
      no_idle = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      $display("run covered %0d values and %0d characters", values_sent, chars_checked);
      $display("radix 0..63 and min_width 0..127 incl. extremes, with stalls on both sides");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
